// ===== hw/rtl/ast_pkg.sv =====
// Shared types and constants for the allocation size tracker.
`timescale 1ns / 1ps

package ast_pkg;

    localparam int ACTION_W  = 2;
    localparam int SIZE_IN_W = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int TOTAL_W   = 38;
    localparam int ENTRY_W   = 32;
    localparam int LIMIT_W   = 7;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Register index is paddr[2]; only index zero exists.
    localparam logic REG_ALLOC_LIMIT = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_ADD    = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_REJECT  = 2'd1,
        ST_NOMATCH = 2'd2
    } status_t;

    typedef struct packed {
        logic    load_item;
        logic    alloc_commit;
        logic    free_commit;
        logic    entry_inc;
        logic    entry_dec;
        logic    rd_start;
        logic    rd_next;
        logic    shift_write;
        logic    status_we;
        status_t status_code;
        logic    result_load;
    } ast_cmd_t;

    typedef struct packed {
        action_t action;
        logic    at_limit;
        logic    list_empty;
        logic    hit;
        logic    last;
    } ast_stat_t;

endpackage

// ===== hw/rtl/ast_in_if.sv =====
// Input channel interface: one action item per transfer.
`timescale 1ns / 1ps

interface ast_in_if
    import ast_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [SIZE_IN_W-1:0] size;

    modport source (output valid, output action, output size, input ready);
    modport sink   (input valid, input action, input size, output ready);
endinterface

// ===== hw/rtl/ast_out_if.sv =====
// Result channel interface: one status and counter snapshot per transfer.
`timescale 1ns / 1ps

interface ast_out_if
    import ast_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  num_blocks;
    logic [TOTAL_W-1:0]  total_bytes;
    logic [ENTRY_W-1:0]  num_entries;

    modport source (output valid, output status, output num_blocks, output total_bytes,
                    output num_entries, input ready);
    modport sink   (input valid, input status, input num_blocks, input total_bytes,
                    input num_entries, output ready);
endinterface

// ===== hw/rtl/ast_ctrl.sv =====
// Controller state machine that sequences allocate, free scan/shift and entry items.
`timescale 1ns / 1ps

module ast_ctrl
    import ast_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    input  ast_stat_t stat,
    output ast_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status_code = ST_DONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.action)
                    ACT_ALLOC:
                    begin
                        cmd.status_we = 1'b1;
                        if (stat.at_limit)
                        begin
                            cmd.status_code = ST_REJECT;
                        end
                        else
                        begin
                            cmd.alloc_commit = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    ACT_FREE:
                    begin
                        if (stat.list_empty)
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = ST_NOMATCH;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    ACT_ADD:
                    begin
                        cmd.entry_inc = 1'b1;
                        cmd.status_we = 1'b1;
                        state_next    = S_FINISH;
                    end
                    ACT_REMOVE:
                    begin
                        cmd.entry_dec = 1'b1;
                        cmd.status_we = 1'b1;
                        state_next    = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                // The read of the next entry is in flight whenever one remains, so a hit can
                // move straight into the shift without a bubble.
                cmd.rd_next = 1'b1;
                if (stat.hit && stat.last)
                begin
                    cmd.free_commit = 1'b1;
                    cmd.status_we   = 1'b1;
                    state_next      = S_FINISH;
                end
                else if (stat.hit)
                begin
                    state_next = S_SHIFT;
                end
                else if (stat.last)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = ST_NOMATCH;
                    state_next      = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                cmd.rd_next     = 1'b1;
                cmd.shift_write = 1'b1;
                if (stat.last)
                begin
                    cmd.free_commit = 1'b1;
                    cmd.status_we   = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ast_datapath.sv =====
// Datapath: size list memory, block count, byte total, entry counter and result registers.
`timescale 1ns / 1ps

module ast_datapath
    import ast_pkg::*;
#(
    parameter int LIST_DEPTH = 64,
    parameter int SIZE_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ast_cmd_t             cmd,
    output ast_stat_t            stat,
    input  logic [ACTION_W-1:0]  in_action,
    input  logic [SIZE_IN_W-1:0] in_size,
    input  logic [LIMIT_W-1:0]   alloc_limit,
    output logic [STATUS_W-1:0]  res_status,
    output logic [COUNT_W-1:0]   res_blocks,
    output logic [TOTAL_W-1:0]   res_total_bytes,
    output logic [ENTRY_W-1:0]   res_entries
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(LIST_DEPTH);

    logic [SIZE_WIDTH-1:0] mem [LIST_DEPTH];

    action_t               action_reg;
    logic [SIZE_WIDTH-1:0] size_reg;
    logic [CNT_W-1:0]      held_reg;
    logic [CNT_W-1:0]      held_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic [ENTRY_W-1:0]    entries_reg;
    logic [ENTRY_W-1:0]    entries_next;
    logic [CNT_W-1:0]      ptr_reg;
    logic [CNT_W-1:0]      data_idx_reg;
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    status_t               status_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [COUNT_W-1:0]    res_count_reg;
    logic [TOTAL_W-1:0]    res_total_reg;
    logic [ENTRY_W-1:0]    res_entry_reg;

    logic                  rd_en;
    logic [CNT_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [CNT_W-1:0]      wr_addr;
    logic [SIZE_WIDTH-1:0] wr_data;
    logic [LIM_W-1:0]      limit_ext;
    logic [LIM_W-1:0]      eff_limit;

    assign limit_ext = LIM_W'(alloc_limit);
    assign eff_limit = (limit_ext > MAX_LIM) ? MAX_LIM : limit_ext;

    assign stat.action     = action_reg;
    assign stat.at_limit   = LIM_W'(held_reg) >= eff_limit;
    assign stat.list_empty = held_reg == '0;
    assign stat.hit        = rd_data_reg == size_reg;
    assign stat.last       = (data_idx_reg + CNT_W'(1)) == held_reg;

    // Reads run one entry ahead of the compare or the shift write.
    assign rd_en   = cmd.rd_start | (cmd.rd_next & (ptr_reg < held_reg));
    assign rd_addr = cmd.rd_start ? '0 : ptr_reg;

    assign wr_en   = cmd.alloc_commit | cmd.shift_write;
    assign wr_addr = cmd.alloc_commit ? held_reg : (data_idx_reg - CNT_W'(1));
    assign wr_data = cmd.alloc_commit ? size_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr[IDX_W-1:0]];
            data_idx_reg <= rd_addr;
            ptr_reg      <= rd_addr + CNT_W'(1);
        end
    end

    always_comb
    begin
        held_next    = held_reg;
        total_next   = total_reg;
        entries_next = entries_reg;
        if (cmd.alloc_commit)
        begin
            held_next  = held_reg + CNT_W'(1);
            total_next = total_reg + TOTAL_W'(size_reg);
        end
        else if (cmd.free_commit)
        begin
            held_next  = held_reg - CNT_W'(1);
            total_next = total_reg - TOTAL_W'(size_reg);
        end
        if (cmd.entry_inc && (entries_reg != '1))
        begin
            entries_next = entries_reg + ENTRY_W'(1);
        end
        else if (cmd.entry_dec && (entries_reg != '0))
        begin
            entries_next = entries_reg - ENTRY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            total_reg   <= '0;
            entries_reg <= '0;
        end
        else
        begin
            held_reg    <= held_next;
            total_reg   <= total_next;
            entries_reg <= entries_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= action_t'(in_action);
            size_reg   <= SIZE_WIDTH'(in_size);
        end
        if (cmd.status_we)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.result_load)
        begin
            res_status_reg <= status_reg;
            res_count_reg  <= COUNT_W'(held_reg);
            res_total_reg  <= total_reg;
            res_entry_reg  <= entries_reg;
        end
    end

    assign res_status      = res_status_reg;
    assign res_blocks      = res_count_reg;
    assign res_total_bytes = res_total_reg;
    assign res_entries     = res_entry_reg;

endmodule

// ===== hw/rtl/allocation_size_tracker_unit.sv =====
// Top level of the allocation size tracker: register port, output slot, controller, datapath.
`timescale 1ns / 1ps

// Tracks a list of allocated block sizes, their byte total and a saturating entry
// counter; every accepted item yields exactly one result. The block works on one
// item at a time. Allocate, entry-added and entry-removed items are taken in the
// idle state, decoded in the execute state and loaded into the output register in
// the finish state. A free item scans the list from the front, one stored entry per
// cycle through the list memory's registered read port, and then shifts the later
// entries down one per cycle on the same read/write port pair, so it passes over
// every held entry whether or not a match is found; on an empty list it goes
// straight to the finish state. The finish state of an item is held for as long as
// the previous result still waits unaccepted in the output register, and a new item
// is taken while a finished result waits there. The size list needs no clearing:
// only entries below the current block count are ever read. alloc_limit sits at
// byte address 0 and resets to 64; values above LIST_DEPTH act as LIST_DEPTH.
module allocation_size_tracker_unit
    import ast_pkg::*;
#(
    parameter int LIST_DEPTH = 64,
    parameter int SIZE_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    ast_in_if.sink            in_ch,
    ast_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    ast_cmd_t           cmd;
    ast_stat_t          stat;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ALLOC_LIMIT);
    assign prdata = (paddr[2] == REG_ALLOC_LIMIT) ? DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // The output slot is free when empty or when its result transfers this cycle.
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid = out_valid_reg;

    ast_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    ast_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_action       (in_ch.action),
        .in_size         (in_ch.size),
        .alloc_limit     (limit_reg),
        .res_status      (out_ch.status),
        .res_blocks      (out_ch.num_blocks),
        .res_total_bytes (out_ch.total_bytes),
        .res_entries     (out_ch.num_entries)
    );

    // A new result must never overwrite one that has not yet transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid_reg || out_ch.ready))
        else $error("result loaded into an occupied output slot");

    // Every item passes through its decode state before a result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !cmd.result_load)
        else $error("result loaded in the cycle after an input transfer");

    // The block count reported can never pass the list capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((LIST_DEPTH > 127) || (32'(out_ch.num_blocks) <= LIST_DEPTH)))
        else $error("reported block count exceeds capacity");

    // A rejected allocation is only reported when the list is at its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.status_we && (cmd.status_code == ST_REJECT)) |-> stat.at_limit)
        else $error("allocation rejected below the limit");

endmodule
